@@ hdl/json_string_unescape_core_defines.svh @@
// Shared assertion macros for the string unescape core.
// Both expect clk_i and rst_ni in the scope of the module that uses them.
`ifndef JSON_STRING_UNESCAPE_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/jsu_pkg.sv @@
package jsu_pkg;

  // Characters with a special role in the string body
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharU         = 8'h75;

  // UTF-8 lead and continuation markers
  localparam logic [7:0] Utf8Lead2   = 8'hC0;
  localparam logic [7:0] Utf8Lead3   = 8'hE0;
  localparam logic [7:0] Utf8Cont    = 8'h80;
  localparam logic [7:0] Utf8SixMask = 8'h3F;
  localparam logic [15:0] Utf8TwoLimit   = 16'h0080;
  localparam logic [15:0] Utf8ThreeLimit = 16'h0800;

  // Number of hex bytes after backslash-u
  localparam logic [2:0] HexDigits = 3'd4;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'b001,
    MODE_ESC   = 3'b010,
    MODE_HEX   = 3'b100
  } jsu_mode_e;

  // Results caused by one input byte: one to three entries
  typedef struct packed {
    logic            has;
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            bvalid;
    logic            done;
    logic            unterm;
  } jsu_group_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
  } jsu_utf8_t;

  // Return {is_hex, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic jsu_utf8_t utf8_encode(input logic [15:0] cp);
    jsu_utf8_t r;
    r.bytes = '0;
    if (cp < Utf8TwoLimit) begin
      r.bytes[0] = cp[7:0];
      r.cnt      = 2'd1;
    end else if (cp < Utf8ThreeLimit) begin
      r.bytes[0] = Utf8Lead2 | {3'd0, cp[10:6]};
      r.bytes[1] = Utf8Cont | ({2'd0, cp[5:0]} & Utf8SixMask);
      r.cnt      = 2'd2;
    end else begin
      r.bytes[0] = Utf8Lead3 | {4'd0, cp[15:12]};
      r.bytes[1] = Utf8Cont | ({2'd0, cp[11:6]} & Utf8SixMask);
      r.bytes[2] = Utf8Cont | ({2'd0, cp[5:0]} & Utf8SixMask);
      r.cnt      = 2'd3;
    end
    return r;
  endfunction

endpackage

@@ hdl/json_string_unescape_core.sv @@
// Streaming unescaper for the body of a JSON string, opening quote already
// consumed. One raw byte enters per transaction; each gives zero to three
// result transactions (plain and escaped bytes give one, a \u escape gives its
// UTF-8 encoding of one to three bytes, a closing quote gives one byte-less
// result with string_done). The input takes a byte every cycle unless
// in_stall_o is high; the path is an input register, combinational decode
// against the escape state, and a result group register that hands out one
// result per cycle while out_stall_i is low. A byte waits in the input register
// until the group register is free. Sustained rate is one input byte per cycle
// while each byte yields at most one result and out_stall_i is low; a byte with
// more results holds the group register, and the input backs up behind it.
module json_string_unescape_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       text_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_done_o,
  output logic       unterminated_o
);

  logic                st_valid;
  logic [7:0]          st_byte;
  logic                st_end;
  logic                grp_free;
  logic                fire;
  jsu_pkg::jsu_group_t grp;

  // Decode when a byte is waiting and the group register frees up
  assign fire = st_valid && grp_free;

  jsu_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .text_end_i (text_end_i),
    .take_i     (grp_free),
    .valid_o    (st_valid),
    .byte_o     (st_byte),
    .end_o      (st_end)
  );

  jsu_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .in_byte_i  (st_byte),
    .text_end_i (st_end),
    .grp_o      (grp)
  );

  jsu_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .grp_i          (grp),
    .free_o         (grp_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .run_last_o     (run_last_o),
    .string_done_o  (string_done_o),
    .unterminated_o (unterminated_o)
  );

endmodule

@@ hdl/jsu_in_stage.sv @@
module jsu_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       text_end_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       end_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       end_q;
  logic       accept;

  // Hold the byte until the decoder can take it
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
      end_q  <= text_end_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign end_o   = end_q;

endmodule

@@ hdl/jsu_decode.sv @@
module jsu_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         in_byte_i,
  input  logic               text_end_i,
  output jsu_pkg::jsu_group_t grp_o
);

  `include "json_string_unescape_core_defines.svh"

  jsu_pkg::jsu_mode_e mode_q, mode_d;
  logic [2:0]         hex_cnt_q, hex_cnt_d;
  logic [15:0]        acc_q, acc_d;
  logic               stop_q, stop_d;

  logic [4:0]         hv;
  logic [15:0]        acc_upd;
  logic [2:0]         cnt_inc;
  jsu_pkg::jsu_utf8_t enc;
  logic [2:0][7:0]    bytes;
  logic [1:0]         nbytes;
  logic               ended;
  logic               unterm;

  assign hv      = jsu_pkg::hex_value(in_byte_i);
  assign acc_upd = (!stop_q && hv[4]) ? {acc_q[11:0], hv[3:0]} : acc_q;
  assign cnt_inc = hex_cnt_q + 3'd1;
  assign enc     = jsu_pkg::utf8_encode(acc_upd);

  // Decode one byte against the escape state
  always_comb begin
    mode_d    = mode_q;
    hex_cnt_d = hex_cnt_q;
    acc_d     = acc_q;
    stop_d    = stop_q;
    bytes     = '0;
    nbytes    = 2'd0;
    ended     = 1'b0;
    unterm    = 1'b0;
    unique case (mode_q)
      jsu_pkg::MODE_ESC: begin
        if (in_byte_i == jsu_pkg::CharU) begin
          mode_d    = jsu_pkg::MODE_HEX;
          hex_cnt_d = 3'd0;
          acc_d     = 16'd0;
          stop_d    = 1'b0;
          // Cut short right after backslash-u: code point zero
          if (text_end_i) begin
            nbytes = 2'd1;
          end
        end else begin
          bytes[0] = jsu_pkg::map_escape(in_byte_i);
          nbytes   = 2'd1;
          mode_d   = jsu_pkg::MODE_PLAIN;
        end
      end
      jsu_pkg::MODE_HEX: begin
        acc_d     = acc_upd;
        stop_d    = stop_q || !hv[4];
        hex_cnt_d = cnt_inc;
        if (cnt_inc >= jsu_pkg::HexDigits || text_end_i) begin
          bytes  = enc.bytes;
          nbytes = enc.cnt;
          mode_d = jsu_pkg::MODE_PLAIN;
        end
      end
      default: begin
        if (in_byte_i == jsu_pkg::CharQuote) begin
          ended = 1'b1;
        end else if (in_byte_i == jsu_pkg::CharBackslash) begin
          mode_d = jsu_pkg::MODE_ESC;
          // Lone backslash at end of text flushes a NUL
          if (text_end_i) begin
            nbytes = 2'd1;
          end
        end else begin
          bytes[0] = in_byte_i;
          nbytes   = 2'd1;
        end
      end
    endcase

    if (!ended && text_end_i) begin
      ended  = 1'b1;
      unterm = 1'b1;
    end

    // Return to plain state once the string is over
    if (ended) begin
      mode_d    = jsu_pkg::MODE_PLAIN;
      hex_cnt_d = 3'd0;
      acc_d     = 16'd0;
      stop_d    = 1'b0;
    end
  end

  // Pack the result group; a flag-only result carries no byte
  always_comb begin
    grp_o.has    = (nbytes != 2'd0) || ended;
    grp_o.bytes  = bytes;
    grp_o.cnt    = (nbytes != 2'd0) ? nbytes : 2'd1;
    grp_o.bvalid = (nbytes != 2'd0);
    grp_o.done   = ended;
    grp_o.unterm = unterm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= jsu_pkg::MODE_PLAIN;
      hex_cnt_q <= 3'd0;
      acc_q     <= 16'd0;
      stop_q    <= 1'b0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      acc_q     <= acc_d;
      stop_q    <= stop_d;
    end
  end

  `JSU_ASSERT_NOW(a_hex_cnt_range, mode_q == jsu_pkg::MODE_HEX, hex_cnt_q < jsu_pkg::HexDigits,
                  "hex digit count ran past four")
  `JSU_ASSERT_NEXT(a_done_resets, fire_i && grp_o.done,
                   mode_q == jsu_pkg::MODE_PLAIN && hex_cnt_q == 3'd0 && acc_q == 16'd0,
                   "decoder state not cleared at end of string")

endmodule

@@ hdl/jsu_out_stage.sv @@
module jsu_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  jsu_pkg::jsu_group_t grp_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic               run_last_o,
  output logic               string_done_o,
  output logic               unterminated_o
);

  `include "json_string_unescape_core_defines.svh"

  logic                valid_q;
  logic [1:0]          idx_q;
  jsu_pkg::jsu_group_t grp_q;
  logic                take;
  logic                last_sel;

  assign take     = valid_q && !out_stall_i;
  assign last_sel = (idx_q == grp_q.cnt - 2'd1);
  assign free_o   = !valid_q || (take && last_sel);

  // Load a new group or step through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (fire_i) begin
      valid_q <= grp_i.has;
      idx_q   <= 2'd0;
    end else if (take) begin
      if (last_sel) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      grp_q <= grp_i;
    end
  end

  // Select the current result
  always_comb begin
    unique case (idx_q)
      2'd0:    out_byte_o = grp_q.bytes[0];
      2'd1:    out_byte_o = grp_q.bytes[1];
      2'd2:    out_byte_o = grp_q.bytes[2];
      default: out_byte_o = 8'd0;
    endcase
  end

  assign out_valid_o    = valid_q;
  assign byte_valid_o   = grp_q.bvalid;
  assign run_last_o     = last_sel;
  assign string_done_o  = last_sel && grp_q.done;
  assign unterminated_o = last_sel && grp_q.done && grp_q.unterm;

  `JSU_ASSERT_NOW(a_idx_in_group, valid_q, idx_q < grp_q.cnt && grp_q.cnt != 2'd0,
                  "result index outside its group")
  `JSU_ASSERT_NOW(a_flag_only, valid_q && !grp_q.bvalid,
                  grp_q.cnt == 2'd1 && grp_q.done && out_byte_o == 8'd0,
                  "byte-less result that does not end the string")
  `JSU_ASSERT_NEXT(a_step_on, take && !last_sel && !fire_i,
                   valid_q && idx_q == $past(idx_q) + 2'd1,
                   "group did not advance after a taken result")

endmodule
